>>> rtl/lzrb_pkg.sv
// Shared types and constants for the LZ ring buffer decompressor.
// Depends on nothing; used by lzrb_ctrl, lzrb_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lzrb_pkg;

    // Parser phase inside the compressed stream.
    typedef enum logic [2:0] {
        PH_TOKEN   = 3'd0,
        PH_LITERAL = 3'd1,
        PH_COUNT   = 3'd2,
        PH_POS_LO  = 3'd3,
        PH_POS_HI  = 3'd4
    } phase_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_CLEAR = 3'd1,
        ST_COPY  = 3'd2,
        ST_EMIT  = 3'd3,
        ST_ERR   = 3'd4,
        ST_READ  = 3'd5
    } state_t;

    // Result error codes.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_COUNT = 2'd1;
    localparam logic [1:0] ERR_POS   = 2'd2;
    localparam logic [1:0] ERR_DONE  = 2'd3;

    // Configuration register indexes.
    localparam logic REG_RING_SEL = 1'b0;
    localparam logic REG_TOTAL    = 1'b1;

    localparam logic [8:0] FLAG_INIT  = 9'h040;
    localparam int         SMALL_RING = 256;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;   // write zero to one ring entry
        logic copy_step;    // write the read byte to the ring, append one lane
        logic lane_reset;   // empty the output lanes
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;   // ring clear sweep reached the last entry
        logic copy_last;    // this copy step moves the final byte
        logic lanes_full;   // output lanes hold a full result
    } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/lzrb_datapath.sv
// Datapath: ring memory, write position, copy source and output lanes.
// Depends on lzrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lzrb_datapath #(
    parameter int RING_DEPTH = 1024,
    parameter int OUT_LANES  = 4
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 ring_sel,
    input  lzrb_pkg::dp_cmd_t                   cmd,
    // Start of a copy: source position and length, or a single literal.
    input  wire                                 load,
    input  wire  [$clog2(RING_DEPTH)-1:0]       load_src,
    input  wire  [8:0]                          load_len,
    input  wire                                 load_lit,
    input  wire  [7:0]                          lit_byte,
    input  wire                                 pos_reset,
    output lzrb_pkg::dp_stat_t                  stat,
    output logic [OUT_LANES*8-1:0]              lanes,
    output logic [$clog2(OUT_LANES+1)-1:0]      lane_cnt
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int LW = $clog2(OUT_LANES + 1);
    localparam logic [AW-1:0] SMALL_MAX = AW'(lzrb_pkg::SMALL_RING - 1);
    localparam logic [AW-1:0] BIG_MAX   = AW'(RING_DEPTH - 1);

    logic [7:0]    ring_mem [RING_DEPTH];
    logic [7:0]    rd_reg;
    logic [AW-1:0] wpos_reg, wpos_next;
    logic [AW-1:0] src_reg, src_next;
    logic [8:0]    len_reg, len_next;
    logic          lit_reg;
    logic [7:0]    litb_reg;
    logic [AW-1:0] clr_reg;
    logic [OUT_LANES*8-1:0] lanes_reg, lanes_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] wmax, wp_mod;
    logic [7:0]    put_byte;

    assign wmax   = ring_sel ? BIG_MAX : SMALL_MAX;
    assign wp_mod = wpos_reg & wmax;

    // Copy byte: the registered ring read, or a literal that bypasses the ring.
    assign put_byte = lit_reg ? litb_reg : rd_reg;

    // Next values for position, source and length counters.
    always_comb
    begin
        wpos_next = wpos_reg;
        src_next  = src_reg;
        len_next  = len_reg;
        if (pos_reset)
        begin
            wpos_next = '0;
        end
        else if (cmd.copy_step)
        begin
            wpos_next = (wp_mod == wmax) ? '0 : wp_mod + 1'b1;
            src_next  = (src_reg == wmax) ? '0 : src_reg + 1'b1;
            len_next  = len_reg - 9'd1;
        end
        if (load)
        begin
            src_next = load_src;
            len_next = load_lit ? 9'd1 : load_len;
        end
    end

    // Output lane packing.
    always_comb
    begin
        lanes_next = lanes_reg;
        cnt_next   = cnt_reg;
        if (cmd.lane_reset)
        begin
            lanes_next = '0;
            cnt_next   = '0;
        end
        if (cmd.copy_step)
        begin
            lanes_next[cnt_next[LW-2:0]*8 +: 8] = put_byte;
            cnt_next = cnt_next + 1'b1;
        end
    end

    // Control registers of the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg  <= '0;
            src_reg   <= '0;
            len_reg   <= '0;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            lanes_reg <= '0;
            lit_reg   <= 1'b0;
        end
        else
        begin
            wpos_reg  <= wpos_next;
            src_reg   <= src_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            lanes_reg <= lanes_next;
            if (load)
                lit_reg <= load_lit;
            if (cmd.clear_step)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (load)
            litb_reg <= lit_byte;
    end

    // Ring memory: a sweep writes zeros, copy steps write decoded bytes; the read is registered.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            ring_mem[clr_reg] <= 8'd0;
        else if (cmd.copy_step)
            ring_mem[wp_mod] <= put_byte;
        rd_reg <= ring_mem[src_reg];
    end

    assign stat.clear_done = (clr_reg == BIG_MAX);
    assign stat.copy_last  = (len_reg == 9'd1);
    assign stat.lanes_full = (cnt_reg == LW'(OUT_LANES));
    assign lanes    = lanes_reg;
    assign lane_cnt = cnt_reg;

endmodule

`default_nettype wire

>>> rtl/lzrb_ctrl.sv
// Controller: token parser, remaining count, result sequencing.
// Depends on lzrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lzrb_ctrl #(
    parameter int RING_DEPTH = 1024
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           ring_sel,
    input  wire  [15:0]                   total,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  [7:0]                    in_byte,
    input  wire                           in_start,
    input  wire                           res_free,
    output logic                          res_push,
    output logic                          res_last,
    output logic                          res_done,
    output logic [1:0]                    res_err,
    input  lzrb_pkg::dp_stat_t            stat,
    output lzrb_pkg::dp_cmd_t             cmd,
    output logic                          load,
    output logic [$clog2(RING_DEPTH)-1:0] load_src,
    output logic [8:0]                    load_len,
    output logic                          load_lit,
    output logic                          pos_reset
);

    localparam int AW = $clog2(RING_DEPTH);

    lzrb_pkg::state_t state_reg, state_next;
    lzrb_pkg::phase_t phase_reg, phase_next;
    logic [8:0]  flag_reg, flag_next;
    logic [15:0] rem_reg, rem_next;
    logic [8:0]  pcnt_reg, pcnt_next;
    logic [7:0]  plo_reg, plo_next;
    logic [1:0]  err_reg, err_next;
    logic        take, start_pend_reg;
    logic [8:0]  neg_cnt, f_sh;
    logic [17:0] pos_full;
    logic [1:0]  copy_err;
    logic        do_copy;
    logic        copy_done_reg;

    assign take    = in_valid && in_ready;
    assign neg_cnt = ((8'd0 - in_byte) == 8'd0) ? 9'd256 : {1'b0, 8'd0 - in_byte};
    assign f_sh    = {flag_reg[7:0], 1'b0};

    // Position of a reference as it completes.
    always_comb
    begin
        if (phase_reg == lzrb_pkg::PH_POS_HI)
            pos_full = {2'b00, in_byte, plo_reg};
        else
            pos_full = {10'd0, in_byte};
    end

    // Parser: next parse state for the accepted byte.
    always_comb
    begin
        phase_next = phase_reg;
        flag_next  = flag_reg;
        rem_next   = rem_reg;
        pcnt_next  = pcnt_reg;
        plo_next   = plo_reg;
        err_next   = err_reg;
        do_copy    = 1'b0;
        load_lit   = 1'b0;
        copy_err   = lzrb_pkg::ERR_NONE;
        if ({7'd0, pcnt_reg} > rem_reg)
            copy_err = lzrb_pkg::ERR_COUNT;
        else if (pos_full >= (ring_sel ? 18'(RING_DEPTH) : 18'(lzrb_pkg::SMALL_RING)))
            copy_err = lzrb_pkg::ERR_POS;
        if (take && rem_reg != 16'd0)
        begin
            case (phase_reg)
                lzrb_pkg::PH_TOKEN:
                begin
                    if (f_sh[7:0] == 8'd0)
                    begin
                        flag_next  = {in_byte, 1'b1};
                        flag_next  = in_byte[7] ? {1'b0, in_byte[6:0], 1'b1}
                                                : {in_byte, 1'b1};
                        phase_next = in_byte[7] ? lzrb_pkg::PH_COUNT
                                                : lzrb_pkg::PH_LITERAL;
                    end
                    else if (f_sh[8])
                    begin
                        flag_next  = {1'b0, f_sh[7:0]};
                        pcnt_next  = neg_cnt;
                        phase_next = lzrb_pkg::PH_POS_LO;
                    end
                    else
                    begin
                        flag_next  = f_sh;
                        load_lit   = 1'b1;
                        do_copy    = 1'b1;
                    end
                end
                lzrb_pkg::PH_LITERAL:
                begin
                    load_lit   = 1'b1;
                    do_copy    = 1'b1;
                    phase_next = lzrb_pkg::PH_TOKEN;
                end
                lzrb_pkg::PH_COUNT:
                begin
                    pcnt_next  = neg_cnt;
                    phase_next = lzrb_pkg::PH_POS_LO;
                end
                lzrb_pkg::PH_POS_LO:
                begin
                    if (ring_sel)
                    begin
                        plo_next   = in_byte;
                        phase_next = lzrb_pkg::PH_POS_HI;
                    end
                    else
                    begin
                        phase_next = lzrb_pkg::PH_TOKEN;
                        err_next   = copy_err;
                        do_copy    = (copy_err == lzrb_pkg::ERR_NONE);
                    end
                end
                default:
                begin
                    phase_next = lzrb_pkg::PH_TOKEN;
                    err_next   = copy_err;
                    do_copy    = (copy_err == lzrb_pkg::ERR_NONE);
                end
            endcase
            if (copy_err != lzrb_pkg::ERR_NONE && !do_copy && !load_lit
                && phase_next == lzrb_pkg::PH_TOKEN
                && phase_reg != lzrb_pkg::PH_TOKEN
                && phase_reg != lzrb_pkg::PH_LITERAL)
                rem_next = 16'd0;
            if (do_copy)
                rem_next = rem_reg - (load_lit ? 16'd1 : {7'd0, pcnt_reg});
        end
        else if (take)
        begin
            err_next = lzrb_pkg::ERR_DONE;
        end
    end

    assign load     = (state_reg == lzrb_pkg::ST_IDLE) && do_copy;
    assign load_src = AW'(pos_full);
    assign load_len = pcnt_reg;

    // Next state; a back reference reads the ring, registered, before each write.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lzrb_pkg::ST_IDLE:
            begin
                if (take && start_pend_reg)
                    state_next = lzrb_pkg::ST_IDLE;
                if (take && (rem_reg == 16'd0 || err_next != lzrb_pkg::ERR_NONE))
                    state_next = lzrb_pkg::ST_ERR;
                else if (load)
                    state_next = load_lit ? lzrb_pkg::ST_COPY : lzrb_pkg::ST_READ;
            end
            lzrb_pkg::ST_CLEAR:
                if (stat.clear_done)
                    state_next = lzrb_pkg::ST_IDLE;
            lzrb_pkg::ST_READ:
                state_next = lzrb_pkg::ST_COPY;
            lzrb_pkg::ST_COPY:
                if (stat.lanes_full || stat.copy_last)
                    state_next = lzrb_pkg::ST_EMIT;
                else
                    state_next = lzrb_pkg::ST_READ;
            lzrb_pkg::ST_EMIT:
                if (res_free)
                    state_next = res_last ? lzrb_pkg::ST_IDLE : lzrb_pkg::ST_COPY;
            lzrb_pkg::ST_ERR:
                if (res_free)
                    state_next = lzrb_pkg::ST_IDLE;
            default:
                state_next = lzrb_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the controller.
    always_comb
    begin
        in_ready       = (state_reg == lzrb_pkg::ST_IDLE)
                         && !(in_valid && in_start && !start_pend_reg);
        cmd.clear_step = (state_reg == lzrb_pkg::ST_CLEAR);
        cmd.copy_step  = (state_reg == lzrb_pkg::ST_COPY) && !stat.lanes_full;
        cmd.lane_reset = (state_reg == lzrb_pkg::ST_EMIT) && res_free;
        res_push       = ((state_reg == lzrb_pkg::ST_EMIT)
                          || (state_reg == lzrb_pkg::ST_ERR)) && res_free;
        res_last       = (state_reg == lzrb_pkg::ST_ERR) || copy_done_reg;
        res_err        = (state_reg == lzrb_pkg::ST_ERR) ? err_reg : lzrb_pkg::ERR_NONE;
        res_done       = (state_reg == lzrb_pkg::ST_ERR) ? (err_reg == lzrb_pkg::ERR_DONE)
                                                         : (copy_done_reg && rem_reg == 16'd0);
        pos_reset      = (state_reg == lzrb_pkg::ST_IDLE) && in_valid && in_start
                         && !start_pend_reg;
    end

    // Tracks whether the copy has moved its final byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            copy_done_reg <= 1'b0;
        else if (load)
            copy_done_reg <= 1'b0;
        else if (cmd.copy_step && stat.copy_last)
            copy_done_reg <= 1'b1;
    end

    // State registers; a stream start runs a ring sweep, then takes the byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lzrb_pkg::ST_IDLE;
            phase_reg      <= lzrb_pkg::PH_TOKEN;
            flag_reg       <= lzrb_pkg::FLAG_INIT;
            rem_reg        <= 16'd0;
            pcnt_reg       <= 9'd0;
            plo_reg        <= 8'd0;
            err_reg        <= lzrb_pkg::ERR_NONE;
            start_pend_reg <= 1'b0;
        end
        else if (pos_reset)
        begin
            state_reg      <= lzrb_pkg::ST_CLEAR;
            phase_reg      <= lzrb_pkg::PH_TOKEN;
            flag_reg       <= lzrb_pkg::FLAG_INIT;
            rem_reg        <= total;
            pcnt_reg       <= 9'd0;
            plo_reg        <= 8'd0;
            err_reg        <= lzrb_pkg::ERR_NONE;
            start_pend_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                phase_reg      <= phase_next;
                flag_reg       <= flag_next;
                rem_reg        <= rem_next;
                pcnt_reg       <= pcnt_next;
                plo_reg        <= plo_next;
                err_reg        <= err_next;
                start_pend_reg <= 1'b0;
            end
        end
    end

    // A copy step only happens in the copy state.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_step |-> state_reg == lzrb_pkg::ST_COPY)
        else $error("copy step outside copy state");
    // No input is taken outside the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        take |-> state_reg == lzrb_pkg::ST_IDLE)
        else $error("input taken while busy");
    // Error results carry the last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_err != lzrb_pkg::ERR_NONE) |-> res_last)
        else $error("error result without last");

endmodule

`default_nettype wire

>>> rtl/lz_ring_buffer_decompressor.sv
// Top level of the LZ ring buffer decompressor: ports, config, output register.
// Depends on lzrb_pkg, lzrb_ctrl and lzrb_datapath.
//
//  channel | direction | handshake           | content
//  s_axis  | in        | tvalid/tready       | tdata=data_byte, tuser=stream_start
//  m_axis  | out       | tvalid/tready       | tdata=bytes,count,done,error; tlast=run_last
//  cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// A literal passes from acceptance through the copy and emit states before the next ready input;
// a back reference reads the ring, registered, before each write in the copy state and passes
// through the emit state for each result, as the ring memory has one read and one write port.
// A stream start first sweeps zeros through every ring entry, then takes the byte.
// After reset the remaining count is zero, so nothing reads the ring before that sweep.
// A stalled output stops the decoder at its next result while the registered one waits.
`timescale 1ns / 1ps
`default_nettype none

module lz_ring_buffer_decompressor #(
    parameter int RING_DEPTH = 1024,
    parameter int OUT_LANES  = 4
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [15:0] cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // data_byte
    input  wire         s_axis_tuser,   // stream_start
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // out_byte0..N-1, byte_count, stream_done, error_code (low bits first)
    output logic [((OUT_LANES*8+$clog2(OUT_LANES+1)+3+7)/8)*8-1:0] m_axis_tdata,
    output logic        m_axis_tlast    // run_last
);

    localparam int LW = $clog2(OUT_LANES + 1);
    localparam int DW = ((OUT_LANES*8 + LW + 3 + 7) / 8) * 8;
    localparam int PW = OUT_LANES*8 + LW + 3;

    logic        sel_reg;
    logic [15:0] total_reg;
    lzrb_pkg::dp_cmd_t  cmd;
    lzrb_pkg::dp_stat_t stat;
    logic        load, load_lit, pos_reset, res_push, res_last, res_done, res_free;
    logic [1:0]  res_err;
    logic [$clog2(RING_DEPTH)-1:0] load_src;
    logic [8:0]  load_len;
    logic [OUT_LANES*8-1:0] lanes;
    logic [LW-1:0] lane_cnt;
    logic [DW-1:0] out_reg;
    logic          ov_reg, ol_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= 1'b0;
            total_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lzrb_pkg::REG_RING_SEL: sel_reg   <= cfg_data[0];
                lzrb_pkg::REG_TOTAL:    total_reg <= cfg_data;
                default:                sel_reg   <= sel_reg;
            endcase
        end
    end

    lzrb_ctrl #(.RING_DEPTH(RING_DEPTH)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .ring_sel(sel_reg), .total(total_reg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_byte(s_axis_tdata), .in_start(s_axis_tuser),
        .res_free(res_free), .res_push(res_push), .res_last(res_last),
        .res_done(res_done), .res_err(res_err), .stat(stat), .cmd(cmd),
        .load(load), .load_src(load_src), .load_len(load_len),
        .load_lit(load_lit), .pos_reset(pos_reset)
    );

    lzrb_datapath #(.RING_DEPTH(RING_DEPTH), .OUT_LANES(OUT_LANES)) u_dp (
        .clk(clk), .rst_n(rst_n), .ring_sel(sel_reg), .cmd(cmd),
        .load(load), .load_src(load_src), .load_len(load_len),
        .load_lit(load_lit), .lit_byte(s_axis_tdata), .pos_reset(pos_reset),
        .stat(stat), .lanes(lanes), .lane_cnt(lane_cnt)
    );

    assign res_free = !ov_reg || m_axis_tready;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (res_free)
            ov_reg <= res_push;
    end

    always_ff @(posedge clk)
    begin
        if (res_push && res_free)
        begin
            out_reg <= DW'(res_err != lzrb_pkg::ERR_NONE
                           ? {res_err, res_done, {(LW + OUT_LANES*8){1'b0}}}
                           : {res_err, res_done, lane_cnt, lanes});
            ol_reg  <= res_last;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tlast  = ol_reg;

    // Result count never exceeds the lane number.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_LANES*8 +: LW] <= LW'(OUT_LANES))
        else $error("byte count above lane number");
    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(m_axis_tvalid && !m_axis_tready) |-> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // Done implies last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[PW-3]) |-> m_axis_tlast)
        else $error("done without last");

endmodule

`default_nettype wire

>>> tb/lz_ring_buffer_decompressor_tb.sv
// Self-checking testbench for lz_ring_buffer_decompressor: drives compressed streams,
// predicts decoded results in a scoreboard class and checks every output transaction.
// Depends on lzrb_pkg and the lz_ring_buffer_decompressor RTL.
`timescale 1ns / 1ps

module lz_ring_buffer_decompressor_tb;

    import lzrb_pkg::*;

    localparam int  RING_DEPTH = 1024;
    localparam int  LANES      = 4;
    localparam int  TDATA_W    = ((LANES*8+$clog2(LANES+1)+3+7)/8)*8;
    localparam int  ITEM_GOAL  = 270;
    localparam int  CYCLE_MAX  = 1500000;

    // One decoded output transaction, lane 0 in the low bits.
    typedef struct packed {
        logic [31:0] lanes;
        logic [2:0]  cnt;
        logic        last;
        logic        done;
        logic [1:0]  err;
    } lz_result_t;

    // Decoder model plus the queue of results it still expects.
    class lz_scoreboard;
        bit          ring_sel;
        bit [15:0]   total_bytes;
        bit [7:0]    ring[RING_DEPTH];
        bit          marks[RING_DEPTH];
        int          wpos;
        bit [8:0]    flags;
        int          remaining;
        phase_t      phase;
        int          ref_count;
        bit [7:0]    pos_low;
        bit [7:0]    decoded[$];
        lz_result_t  pending_q[$];
        int          errors;

        function new();
            for (int i = 0; i < RING_DEPTH; i++) marks[i] = 0;
            ring_sel = 0;
            total_bytes = 0;
            wpos = 0;
            flags = FLAG_INIT;
            remaining = 0;
            phase = PH_TOKEN;
            ref_count = 0;
            pos_low = 0;
            errors = 0;
        endfunction

        function void set_reg(logic idx, bit [15:0] v);
            if (idx == REG_RING_SEL) ring_sel = v[0];
            else total_bytes = v;
        endfunction

        function int ring_len();
            return ring_sel ? RING_DEPTH : SMALL_RING;
        endfunction

        function void put_byte(bit [7:0] b);
            int sz;
            int wp;
            sz = ring_len();
            wp = wpos % sz;
            ring[wp] = b;
            marks[wp] = 1;
            wp++;
            wpos = (wp >= sz) ? 0 : wp;
            decoded.push_back(b);
        endfunction

        // Returns an error code, or ERR_NONE after copying the reference.
        function logic [1:0] copy_ref(int pos);
            int sz;
            int src;
            sz = ring_len();
            src = pos;
            if (ref_count > remaining) return ERR_COUNT;
            if (pos >= sz) return ERR_POS;
            for (int k = 0; k < ref_count; k++)
            begin
                put_byte(marks[src] ? ring[src] : 8'h00);
                src = (src + 1 >= sz) ? 0 : src + 1;
            end
            return ERR_NONE;
        endfunction

        function void push_error(logic [1:0] code, logic done);
            lz_result_t r;
            r = '0;
            r.last = 1;
            r.done = done;
            r.err = code;
            pending_q.push_back(r);
        endfunction

        function int neg_count(bit [7:0] b);
            bit [7:0] n;
            n = 8'd0 - b;
            return (n == 0) ? 256 : int'(n);
        endfunction

        // Called for every accepted input transaction.
        function void note_input(bit [7:0] b, bit start);
            bit [8:0]   f;
            logic [1:0] err;
            int         nres;
            lz_result_t r;
            if (start)
            begin
                for (int i = 0; i < RING_DEPTH; i++) marks[i] = 0;
                wpos = 0;
                flags = FLAG_INIT;
                remaining = int'(total_bytes);
                phase = PH_TOKEN;
                ref_count = 0;
                pos_low = 0;
            end
            if (remaining == 0)
            begin
                push_error(ERR_DONE, 1);
                return;
            end
            decoded.delete();
            err = ERR_NONE;
            case (phase)
                PH_TOKEN:
                begin
                    f = {flags[7:0], 1'b0};
                    if (f[7:0] == 0)
                    begin
                        // Flag byte: first bit picked right away.
                        f = {b, 1'b1};
                        flags = f[8] ? {1'b0, f[7:0]} : f;
                        phase = f[8] ? PH_COUNT : PH_LITERAL;
                        return;
                    end
                    if (f[8])
                    begin
                        flags = {1'b0, f[7:0]};
                        ref_count = neg_count(b);
                        phase = PH_POS_LO;
                        return;
                    end
                    flags = f;
                    put_byte(b);
                end
                PH_LITERAL: put_byte(b);
                PH_COUNT:
                begin
                    ref_count = neg_count(b);
                    phase = PH_POS_LO;
                    return;
                end
                PH_POS_LO:
                begin
                    if (ring_sel)
                    begin
                        pos_low = b;
                        phase = PH_POS_HI;
                        return;
                    end
                    err = copy_ref(int'(b));
                end
                default: err = copy_ref(int'({b, pos_low}));
            endcase
            phase = PH_TOKEN;
            if (err != ERR_NONE)
            begin
                remaining = 0;
                push_error(err, 0);
                return;
            end
            remaining = (remaining - decoded.size()) & 16'hffff;
            nres = (decoded.size() + LANES - 1) / LANES;
            for (int k = 0; k < nres; k++)
            begin
                r = '0;
                for (int j = 0; j < LANES; j++)
                    if (k*LANES + j < decoded.size())
                    begin
                        r.lanes[j*8 +: 8] = decoded[k*LANES + j];
                        r.cnt = 3'(j + 1);
                    end
                r.last = (k == nres - 1);
                r.done = r.last && (remaining == 0);
                r.err = ERR_NONE;
                pending_q.push_back(r);
            end
        endfunction

        // Called for every accepted output transaction.
        function void check(lz_result_t a);
            lz_result_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, a);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (a.lanes !== e.lanes)
                $display("%0t: lanes expected %h actual %h", $time, e.lanes, a.lanes);
            if (a.cnt !== e.cnt)
                $display("%0t: byte_count expected %0d actual %0d", $time, e.cnt, a.cnt);
            if (a.last !== e.last)
                $display("%0t: run_last expected %0d actual %0d", $time, e.last, a.last);
            if (a.done !== e.done)
                $display("%0t: stream_done expected %0d actual %0d", $time, e.done, a.done);
            if (a.err !== e.err)
                $display("%0t: error_code expected %0d actual %0d", $time, e.err, a.err);
            if (a !== e) errors++;
        endfunction
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_we = 0;
    logic               cfg_index = 0;
    logic [15:0]        cfg_data = 0;
    logic               s_axis_tvalid = 0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 0;   // data_byte
    logic               s_axis_tuser = 0;   // stream_start
    logic               m_axis_tvalid;
    logic               m_axis_tready = 0;
    // out_byte0..3, byte_count, stream_done, error_code (low bits first)
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;       // run_last

    lz_scoreboard sb = new();
    int           items_sent = 0;
    int           burst_left = 0;
    int           cycles = 0;
    int           stall_mode = 0;

    lz_ring_buffer_decompressor #(.RING_DEPTH(RING_DEPTH), .OUT_LANES(LANES)) DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_MAX)
        begin
            $display("lz_ring_buffer_decompressor: mismatch");
            $finish;
        end
    end

    // Receiver stalls, switching pattern periodically.
    always @(posedge clk)
    begin
        if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0, 1: m_axis_tready <= 1'b1;
            2: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Output monitor.
    always @(posedge clk)
    begin
        lz_result_t a;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            a.lanes = m_axis_tdata[31:0];
            a.cnt = m_axis_tdata[34:32];
            a.done = m_axis_tdata[35];
            a.err = m_axis_tdata[37:36];
            a.last = m_axis_tlast;
            sb.check(a);
        end
    end

    task automatic write_reg(logic idx, bit [15:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // Sends one byte in bursts with random gaps between them.
    task automatic send_byte(bit [7:0] b, bit start);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= start;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(b, start);
        items_sent++;
    endtask

    // Stops sending and waits until every expected result has arrived.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // One well-formed stream with random content and occasional bad references.
    task automatic gen_stream(int ntok);
        bit [7:0] flag;
        int       tok;
        int       cnt;
        int       cap;
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        tok = 1;
        while (tok < ntok && sb.remaining > 0)
        begin
            flag = 8'($urandom_range(0, 255));
            send_byte(flag, 1'b0);
            for (int i = 7; i >= 0 && tok < ntok && sb.remaining > 0; i--)
            begin
                tok++;
                if (!flag[i])
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                    continue;
                end
                cap = (sb.remaining < 12) ? sb.remaining : 12;
                case ($urandom_range(0, 19))
                    0: cnt = 256;
                    1: cnt = sb.remaining + 1;
                    default: cnt = $urandom_range(1, cap);
                endcase
                if (cnt > 256) cnt = 256;
                send_byte(8'((256 - cnt) & 8'hff), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b0);
                if (sb.ring_sel)
                    send_byte(8'(($urandom_range(0, 14) == 0) ? $urandom_range(0, 255)
                                                              : $urandom_range(0, 3)), 1'b0);
            end
        end
        // Sometimes bytes past the end of the stream.
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Byte after reset with no stream start.
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        drain();

        // Small ring: oversized count, then overlapping copy and unwritten read.
        write_reg(REG_RING_SEL, 16'd0);
        write_reg(REG_TOTAL, 16'd20);
        send_byte(8'hff, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hc0, 1'b0);
        send_byte(8'hfb, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hfd, 1'b0);
        send_byte(8'h80, 1'b0);
        drain();

        // Large ring: full 256-byte copy, position past the ring, byte after done.
        write_reg(REG_RING_SEL, 16'd1);
        write_reg(REG_TOTAL, 16'hffff);
        send_byte(8'h5a, 1'b1);
        send_byte(8'hc0, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h77, 1'b0);
        drain();

        // Random streams over a spread of settings.
        while (items_sent < ITEM_GOAL)
        begin
            write_reg(REG_RING_SEL, 16'($urandom_range(0, 1)));
            case ($urandom_range(0, 9))
                0: write_reg(REG_TOTAL, 16'd1);
                1: write_reg(REG_TOTAL, 16'hffff);
                2: write_reg(REG_TOTAL, 16'($urandom_range(100, 400)));
                default: write_reg(REG_TOTAL, 16'($urandom_range(2, 80)));
            endcase
            repeat ($urandom_range(1, 3)) gen_stream($urandom_range(4, 30));
            drain();
        end

        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("lz_ring_buffer_decompressor: match");
        else
        begin
            if (sb.pending_q.size() != 0)
                $display("%0t: %0d expected results never arrived", $time,
                         sb.pending_q.size());
            $display("lz_ring_buffer_decompressor: mismatch");
        end
        $finish;
    end

endmodule
